FILE: rtl/core/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// shared types, codes and helpers of the shape compass point pipeline
// ----------------------------------------------------------------------------
package scp_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int MAG_W   = COORD_W;
    localparam int SQR_W   = 2 * MAG_W;
    localparam int SUM_W   = SQR_W + 1;
    localparam int ROOT_W  = (SUM_W + 1) / 2;
    localparam int REM_W   = SUM_W + 2;
    localparam int RAD_W   = ROOT_W + 2;
    localparam int IW      = COORD_W + 6;

    localparam int FRAC_BITS_DEF = 16;

    localparam logic [2:0] KIND_PLACE  = 3'd0;
    localparam logic [2:0] KIND_BOX    = 3'd1;
    localparam logic [2:0] KIND_ARC    = 3'd2;
    localparam logic [2:0] KIND_CIRCLE = 3'd3;
    localparam logic [2:0] KIND_LINE   = 3'd4;

    localparam logic [3:0] CRN_CENTER = 4'd0;
    localparam logic [3:0] CRN_N      = 4'd1;
    localparam logic [3:0] CRN_S      = 4'd2;
    localparam logic [3:0] CRN_E      = 4'd3;
    localparam logic [3:0] CRN_W      = 4'd4;
    localparam logic [3:0] CRN_NE     = 4'd5;
    localparam logic [3:0] CRN_NW     = 4'd6;
    localparam logic [3:0] CRN_SE     = 4'd7;
    localparam logic [3:0] CRN_SW     = 4'd8;
    localparam logic [3:0] CRN_START  = 4'd9;
    localparam logic [3:0] CRN_END    = 4'd10;

    typedef struct packed {
        logic [2:0]                 shape_kind;
        logic [3:0]                 corner;
        logic signed [COORD_W-1:0]  ref_x;
        logic signed [COORD_W-1:0]  ref_y;
        logic signed [COORD_W-1:0]  extent_x;
        logic signed [COORD_W-1:0]  extent_y;
        logic signed [COORD_W-1:0]  arc_end_x;
        logic signed [COORD_W-1:0]  arc_end_y;
        logic                       clockwise;
    } scp_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0]  pos_x;
        logic signed [COORD_W-1:0]  pos_y;
    } scp_out_t;

    typedef struct packed {
        scp_in_t                    item;
        logic [REM_W-1:0]           rem;
        logic [ROOT_W-1:0]          root;
    } scp_sq_t;

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] hi;
        logic signed [IW-1:0] lo;
        logic signed [COORD_W-1:0] r;
        hi = IW'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
        lo = IW'(signed'({1'b1, {(COORD_W-1){1'b0}}}));
        if (v > hi)
        begin
            r = hi[COORD_W-1:0];
        end
        else if (v < lo)
        begin
            r = lo[COORD_W-1:0];
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/scp_front.sv
// ----------------------------------------------------------------------------
// scp_front
// three stages forming the squared arc start distance for the root pipeline
// ----------------------------------------------------------------------------
module scp_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  scp_pkg::scp_in_t item_in,
    output logic             vld_out,
    output scp_pkg::scp_sq_t data_out
);
    import scp_pkg::*;

    logic                       a_vld_reg;
    scp_in_t                    a_item_reg;
    logic [MAG_W-1:0]           a_mag_reg;
    logic [MAG_W-1:0]           b_mag_reg;
    logic [MAG_W-1:0]           a_mag_next;
    logic [MAG_W-1:0]           b_mag_next;

    logic                       b_vld_reg;
    scp_in_t                    b_item_reg;
    logic [SQR_W-1:0]           a_sqr_reg;
    logic [SQR_W-1:0]           b_sqr_reg;
    logic [SQR_W-1:0]           a_sqr_next;
    logic [SQR_W-1:0]           b_sqr_next;

    logic                       c_vld_reg;
    scp_sq_t                    c_data_reg;
    scp_sq_t                    c_data_next;

    logic signed [DIFF_W-1:0]   dx;
    logic signed [DIFF_W-1:0]   dy;
    logic signed [DIFF_W-1:0]   ax;
    logic signed [DIFF_W-1:0]   ay;

    always_comb
    begin
        dx = DIFF_W'($signed(item_in.extent_x)) - DIFF_W'($signed(item_in.ref_x));
        dy = DIFF_W'($signed(item_in.extent_y)) - DIFF_W'($signed(item_in.ref_y));
        ax = dx[DIFF_W-1] ? -dx : dx;
        ay = dy[DIFF_W-1] ? -dy : dy;
        a_mag_next = ax[MAG_W-1:0];
        b_mag_next = ay[MAG_W-1:0];
    end

    assign a_sqr_next = SQR_W'(a_mag_reg) * SQR_W'(a_mag_reg);
    assign b_sqr_next = SQR_W'(b_mag_reg) * SQR_W'(b_mag_reg);

    always_comb
    begin
        c_data_next.item = b_item_reg;
        c_data_next.rem  = REM_W'(SUM_W'(a_sqr_reg) + SUM_W'(b_sqr_reg));
        c_data_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= vld_in;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= item_in;
            a_mag_reg  <= a_mag_next;
            b_mag_reg  <= b_mag_next;
            b_item_reg <= a_item_reg;
            a_sqr_reg  <= a_sqr_next;
            b_sqr_reg  <= b_sqr_next;
            c_data_reg <= c_data_next;
        end
    end

    assign vld_out  = c_vld_reg;
    assign data_out = c_data_reg;

endmodule

FILE: rtl/core/scp_sqrt_stage.sv
// ----------------------------------------------------------------------------
// scp_sqrt_stage
// one bit of the restoring integer square root
// ----------------------------------------------------------------------------
module scp_sqrt_stage #(
    parameter int BIT = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  scp_pkg::scp_sq_t data_in,
    output logic             vld_out,
    output scp_pkg::scp_sq_t data_out
);
    import scp_pkg::*;

    logic             vld_reg;
    scp_sq_t          data_reg;
    scp_sq_t          data_next;
    logic [REM_W-1:0] trial;
    logic             take;

    always_comb
    begin
        trial = (REM_W'(data_in.root) << (BIT + 1)) + (REM_W'(1) << (2 * BIT));
        take  = data_in.rem >= trial;
        data_next      = data_in;
        if (take)
        begin
            data_next.rem  = data_in.rem - trial;
            data_next.root = data_in.root | (ROOT_W'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign vld_out  = vld_reg;
    assign data_out = data_reg;

endmodule

FILE: rtl/core/scp_back.sv
// ----------------------------------------------------------------------------
// scp_back
// diagonal scaling stage and point selection with saturating result register
// ----------------------------------------------------------------------------
module scp_back #(
    parameter int FRAC_BITS = scp_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              vld_in,
    input  scp_pkg::scp_sq_t  data_in,
    output logic              vld_out,
    output scp_pkg::scp_out_t res_out
);
    import scp_pkg::*;

    localparam int    KW     = FRAC_BITS + 1;
    localparam int    PW     = RAD_W + KW;
    localparam longint DIAG_L = ((longint'(707) << FRAC_BITS) + 500) / 1000;
    localparam logic signed [KW-1:0] DIAG_K = KW'(DIAG_L);
    localparam logic signed [PW-1:0] HALF   = PW'(longint'(1) << (FRAC_BITS - 1));

    logic                     d_vld_reg;
    scp_in_t                  d_item_reg;
    logic signed [RAD_W-1:0]  d_rx_reg;
    logic signed [RAD_W-1:0]  d_ry_reg;
    logic signed [PW-1:0]     d_px_reg;
    logic signed [PW-1:0]     d_py_reg;
    logic signed [RAD_W-1:0]  d_rx_next;
    logic signed [RAD_W-1:0]  d_ry_next;
    logic signed [PW-1:0]     d_px_next;
    logic signed [PW-1:0]     d_py_next;

    logic                     res_vld_reg;
    scp_out_t                 res_reg;
    scp_out_t                 res_next;

    logic signed [IW-1:0]     x;
    logic signed [IW-1:0]     y;
    logic signed [IW-1:0]     x1;
    logic signed [IW-1:0]     y1;
    logic signed [IW-1:0]     rx;
    logic signed [IW-1:0]     ry;
    logic signed [IW-1:0]     gx;
    logic signed [IW-1:0]     gy;
    logic signed [PW-1:0]     rnd_x;
    logic signed [PW-1:0]     rnd_y;
    logic signed [IW-1:0]     ox;
    logic signed [IW-1:0]     oy;

    always_comb
    begin
        if (data_in.item.shape_kind == KIND_ARC)
        begin
            d_rx_next = $signed({{(RAD_W-ROOT_W){1'b0}}, data_in.root});
            d_ry_next = $signed({{(RAD_W-ROOT_W){1'b0}}, data_in.root});
        end
        else
        begin
            d_rx_next = RAD_W'($signed(data_in.item.extent_x));
            d_ry_next = RAD_W'($signed(data_in.item.extent_y));
        end
        d_px_next = PW'(d_rx_next) * PW'(DIAG_K);
        d_py_next = PW'(d_ry_next) * PW'(DIAG_K);
    end

    always_comb
    begin
        x     = IW'($signed(d_item_reg.ref_x));
        y     = IW'($signed(d_item_reg.ref_y));
        x1    = IW'($signed(d_item_reg.extent_x));
        y1    = IW'($signed(d_item_reg.extent_y));
        rx    = IW'(d_rx_reg);
        ry    = IW'(d_ry_reg);
        rnd_x = d_px_reg + HALF;
        rnd_y = d_py_reg + HALF;
        gx    = IW'(rnd_x >>> FRAC_BITS);
        gy    = IW'(rnd_y >>> FRAC_BITS);
        ox    = x;
        oy    = y;
        case (d_item_reg.shape_kind) inside
            KIND_BOX:
            begin
                case (d_item_reg.corner)
                    CRN_N:  oy = ((y <<< 1) + y1) >>> 1;
                    CRN_S:  oy = ((y <<< 1) - y1) >>> 1;
                    CRN_E:  ox = ((x <<< 1) + x1) >>> 1;
                    CRN_W:  ox = ((x <<< 1) - x1) >>> 1;
                    CRN_NE:
                    begin
                        ox = ((x <<< 1) + x1) >>> 1;
                        oy = ((y <<< 1) + y1) >>> 1;
                    end
                    CRN_NW:
                    begin
                        ox = ((x <<< 1) - x1) >>> 1;
                        oy = ((y <<< 1) + y1) >>> 1;
                    end
                    CRN_SE:
                    begin
                        ox = ((x <<< 1) + x1) >>> 1;
                        oy = ((y <<< 1) - y1) >>> 1;
                    end
                    CRN_SW:
                    begin
                        ox = ((x <<< 1) - x1) >>> 1;
                        oy = ((y <<< 1) - y1) >>> 1;
                    end
                    default: ;
                endcase
            end
            KIND_ARC, KIND_CIRCLE:
            begin
                if (d_item_reg.shape_kind == KIND_ARC && d_item_reg.corner == CRN_START)
                begin
                    ox = d_item_reg.clockwise ? IW'($signed(d_item_reg.arc_end_x)) : x1;
                    oy = d_item_reg.clockwise ? IW'($signed(d_item_reg.arc_end_y)) : y1;
                end
                else if (d_item_reg.shape_kind == KIND_ARC && d_item_reg.corner == CRN_END)
                begin
                    ox = d_item_reg.clockwise ? x1 : IW'($signed(d_item_reg.arc_end_x));
                    oy = d_item_reg.clockwise ? y1 : IW'($signed(d_item_reg.arc_end_y));
                end
                else
                begin
                    case (d_item_reg.corner)
                        CRN_N:  oy = y + ry;
                        CRN_S:  oy = y - ry;
                        CRN_E:  ox = x + rx;
                        CRN_W:  ox = x - rx;
                        CRN_NE:
                        begin
                            ox = x + gx;
                            oy = y + gy;
                        end
                        CRN_NW:
                        begin
                            ox = x - gx;
                            oy = y + gy;
                        end
                        CRN_SE:
                        begin
                            ox = x + gx;
                            oy = y - gy;
                        end
                        CRN_SW:
                        begin
                            ox = x - gx;
                            oy = y - gy;
                        end
                        default: ;
                    endcase
                end
            end
            KIND_LINE:
            begin
                case (d_item_reg.corner)
                    CRN_START: ;
                    CRN_END:
                    begin
                        ox = x1;
                        oy = y1;
                    end
                    CRN_N:
                    begin
                        if (y1 > y)
                        begin
                            ox = x1;
                            oy = y1;
                        end
                    end
                    CRN_S:
                    begin
                        if (y1 < y)
                        begin
                            ox = x1;
                            oy = y1;
                        end
                    end
                    CRN_E:
                    begin
                        if (x1 > x)
                        begin
                            ox = x1;
                            oy = y1;
                        end
                    end
                    CRN_W:
                    begin
                        if (x1 < x)
                        begin
                            ox = x1;
                            oy = y1;
                        end
                    end
                    default:
                    begin
                        ox = (x + x1) >>> 1;
                        oy = (y + y1) >>> 1;
                    end
                endcase
            end
            default: ;
        endcase
        res_next.pos_x = sat_coord(ox);
        res_next.pos_y = sat_coord(oy);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg   <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            d_vld_reg   <= vld_in;
            res_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_item_reg <= data_in.item;
            d_rx_reg   <= d_rx_next;
            d_ry_reg   <= d_ry_next;
            d_px_reg   <= d_px_next;
            d_py_reg   <= d_py_next;
            res_reg    <= res_next;
        end
    end

    assign vld_out = res_vld_reg;
    assign res_out = res_reg;

endmodule

FILE: rtl/core/shape_compass_point_top.sv
// ----------------------------------------------------------------------------
// shape_compass_point_top
// Returns the coordinates of a named compass point on a drawn shape. One
// request enters per clock while the pipeline is not held. The front stages
// form the squared arc start distance, a root stage for each root bit works
// through the 33-bit integer square root, and the back stages scale diagonals
// by 0.707 and pick and saturate the point. Every request passes the whole
// pipeline, arc or not. When the result register holds an untaken result and
// result_stall is high, the whole pipeline holds and request_stall is raised.
// ----------------------------------------------------------------------------
module shape_compass_point_top #(
    parameter int FRAC_BITS = scp_pkg::FRAC_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              request_valid,
    output logic              request_stall,
    input  scp_pkg::scp_in_t  request,
    output logic              result_valid,
    input  logic              result_stall,
    output scp_pkg::scp_out_t result
);
    import scp_pkg::*;

    logic          en;
    logic          sq_vld  [ROOT_W+1];
    scp_sq_t       sq_data [ROOT_W+1];

    assign en            = !result_valid || !result_stall;
    assign request_stall = !en;

    scp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (request_valid),
        .item_in  (request),
        .vld_out  (sq_vld[0]),
        .data_out (sq_data[0])
    );

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_root
        scp_sqrt_stage #(
            .BIT (ROOT_W - 1 - i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .vld_in   (sq_vld[i]),
            .data_in  (sq_data[i]),
            .vld_out  (sq_vld[i+1]),
            .data_out (sq_data[i+1])
        );
    end

    scp_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (sq_vld[ROOT_W]),
        .data_in (sq_data[ROOT_W]),
        .vld_out (result_valid),
        .res_out (result)
    );

    a_root_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sq_vld[ROOT_W] |->
            sq_data[ROOT_W].rem <= (REM_W'(sq_data[ROOT_W].root) << 1))
        else $error("square root remainder out of range");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        request_stall |=> $stable(sq_vld[0]) && $stable(sq_vld[ROOT_W]) && result_valid)
        else $error("pipeline moved while held");

endmodule
